/* hdl/tep_pkg.sv */
// package for the table entry replacement block
// item and result structs, operation codes, controller to datapath command/status
// no dependencies
package tep_pkg;

  // table geometry
  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int PTR_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int SIZE_W  = 16;
  localparam int STAMP_W = 32;

  // item function codes
  localparam logic FUNC_FILL    = 1'b0;
  localparam logic FUNC_REPLACE = 1'b1;

  // victim policy codes
  localparam logic POLICY_CIRC = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef struct packed {
    logic               func;
    logic [IDX_W-1:0]   index;
    logic [KEY_W-1:0]   key;
    logic [SIZE_W-1:0]  size;
    logic [STAMP_W-1:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic             replaced;
    logic [IDX_W-1:0] victim_index;
  } out_item_t;

  // datapath commit operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_FILL,
    OP_EMPTY,
    OP_CIRC,
    OP_LRU
  } op_t;

  typedef struct packed {
    logic load;
    logic scan_clear;
    logic scan_run;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic full;
    logic policy;
    logic scan_done;
  } sts_t;

endpackage

/* hdl/table_entry_replacement_top.sv */
// Table entry replacement block, top level.
//
// Channels:
//   in_item  : fill or replace item, taken at a clock edge with start high and busy low.
//   out_item : one result per item, shown for exactly one cycle with out_valid high;
//              the receiver takes it at the edge that ends that cycle and cannot stall.
//   cfg_*    : policy register write, taken when cfg_valid and cfg_ready are high;
//              cfg_ready is high whenever no item is in progress.
// Sequence: a fill, a replace on a table that is not full, and a circular-pointer
//   replace are settled in the decide state, the only busy state, and their result is strobed.
//   A least-recent replace walks the stamp memory one entry per cycle through its
//   single registered read port in the scan state before its result is strobed;
//   busy covers the decide and scan states.
// Throughput: one item at a time; a new item may be started in the cycle the
//   previous result is strobed.
// Reset: synchronous active-low rst_n clears all valid marks, the fill count, the
//   circular pointer and the policy (circular); no clearing pass is needed.
//   Entry key, size and stamp memories are not cleared.
// Depends on tep_pkg, tep_ctrl and tep_datapath.
module table_entry_replacement_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tep_pkg::in_item_t   in_item,
  output logic                out_valid,
  output tep_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import tep_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  // config transfer
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  tep_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  tep_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

`ifndef SYNTHESIS
  // no result in the cycle right after an item transfer
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result strobed one cycle after item transfer");

  // result strobe only while the block is idle
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  // strobe lasts a single cycle
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // a replace result never reports a victim while the table was not full
  a_replace_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.replaced) |-> sts.full)
    else $error("victim reported on a table that is not full");
`endif

endmodule

/* hdl/tep_ctrl.sv */
// controller for the table entry replacement block
// sequences decide, least-recent scan and commit; drives the result strobe
// depends on tep_pkg
module tep_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  input  tep_pkg::sts_t sts,
  output tep_pkg::cmd_t cmd
);
  import tep_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    cmd.load       = 1'b0;
    cmd.scan_clear = 1'b0;
    cmd.scan_run   = 1'b0;
    cmd.op         = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.func == FUNC_FILL) begin
          cmd.op        = OP_FILL;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (!sts.full) begin
          cmd.op        = OP_EMPTY;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (sts.policy == POLICY_CIRC) begin
          cmd.op        = OP_CIRC;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.scan_clear = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          cmd.op        = OP_LRU;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hdl/tep_datapath.sv */
// datapath for the table entry replacement block
// entry memories, valid marks and count, circular pointer, least-recent scan, result
// depends on tep_pkg
module tep_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  tep_pkg::in_item_t in_item,
  input  logic              cfg_we,
  input  logic              cfg_data,
  input  tep_pkg::cmd_t     cmd,
  output tep_pkg::sts_t     sts,
  output tep_pkg::out_item_t out_item
);
  import tep_pkg::*;

  localparam int RD_W = $clog2(ENTRIES + 1);

  in_item_t            item_r;
  logic                policy_r;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  out_item_t           out_r;

  // entry storage
  logic [STAMP_W-1:0]        stamp_mem [ENTRIES];
  logic [KEY_W+SIZE_W-1:0]   ksz_mem   [ENTRIES];

  // scan state
  logic [RD_W-1:0]    rd_addr_r;
  logic [STAMP_W-1:0] rd_data_r;
  logic               cmp_vld_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic [STAMP_W-1:0] best_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic               scan_done_r;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] circ_pos;
  logic             rd_en;

  // circular victim: wraps to entry 0 once the pointer runs past the end
  assign circ_pos = (ptr_r < PTR_W'(ENTRIES)) ? ptr_r[IDX_W-1:0] : '0;

  // write address and enable per operation
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    case (cmd.op)
      OP_FILL: begin
        wr_en   = 1'b1;
        wr_addr = item_r.index;
      end
      OP_CIRC: begin
        wr_en   = 1'b1;
        wr_addr = circ_pos;
      end
      OP_LRU: begin
        wr_en   = 1'b1;
        wr_addr = best_idx_r;
      end
      default: begin
        wr_en   = 1'b0;
        wr_addr = '0;
      end
    endcase
  end

  // valid marks and fill count
  always_comb begin
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    if (wr_en && !valid_r[wr_addr]) begin
      valid_nxt[wr_addr] = 1'b1;
      cnt_nxt            = cnt_r + CNT_W'(1);
    end
  end

  // pointer advance
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.op == OP_CIRC) begin
      ptr_nxt = (ptr_r < PTR_W'(ENTRIES)) ? ptr_r + PTR_W'(1) : PTR_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_CIRC;
      valid_r  <= '0;
      cnt_r    <= '0;
      ptr_r    <= '0;
    end else begin
      if (cfg_we) begin
        policy_r <= cfg_data;
      end
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // item capture and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    case (cmd.op)
      OP_FILL: begin
        out_r.replaced     <= 1'b0;
        out_r.victim_index <= item_r.index;
      end
      OP_EMPTY: begin
        out_r.replaced     <= 1'b0;
        out_r.victim_index <= '0;
      end
      OP_CIRC, OP_LRU: begin
        out_r.replaced     <= 1'b1;
        out_r.victim_index <= wr_addr;
      end
      default: begin
        out_r <= out_r;
      end
    endcase
  end

  assign rd_en = cmd.scan_run && (rd_addr_r < RD_W'(ENTRIES));

  // entry memories: one write port, one registered read port on stamps
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamp_mem[wr_addr] <= item_r.stamp;
      ksz_mem[wr_addr]   <= {item_r.key, item_r.size};
    end
    if (rd_en) begin
      rd_data_r <= stamp_mem[rd_addr_r[IDX_W-1:0]];
    end
  end

  // scan sequencing: one read issued per cycle, each compared in the cycle after its read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r   <= '0;
      cmp_vld_r   <= 1'b0;
      scan_done_r <= 1'b0;
    end else if (cmd.scan_clear) begin
      rd_addr_r   <= '0;
      cmp_vld_r   <= 1'b0;
      scan_done_r <= 1'b0;
    end else if (cmd.scan_run) begin
      cmp_vld_r <= rd_en;
      if (rd_en) begin
        rd_addr_r <= rd_addr_r + RD_W'(1);
      end
      if (cmp_vld_r && (cmp_idx_r == IDX_W'(ENTRIES - 1))) begin
        scan_done_r <= 1'b1;
      end
    end
  end

  // running minimum, strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cmp_idx_r <= rd_addr_r[IDX_W-1:0];
    end
    if (cmd.scan_run && cmp_vld_r) begin
      if ((cmp_idx_r == '0) || (rd_data_r < best_r)) begin
        best_r     <= rd_data_r;
        best_idx_r <= cmp_idx_r;
      end
    end
  end

  assign sts.func      = item_r.func;
  assign sts.full      = (cnt_r == CNT_W'(ENTRIES));
  assign sts.policy    = policy_r;
  assign sts.scan_done = scan_done_r;
  assign out_item      = out_r;

endmodule
